// ===== rtl/weighted_cell_sampler_macros.svh =====
// Assertion macros shared by the weighted cell sampler RTL.
`ifndef WEIGHTED_CELL_SAMPLER_MACROS_SVH
`define WEIGHTED_CELL_SAMPLER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define WCS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define WCS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/wcs_pkg.sv =====
// Shared types and constants for the weighted cell sampler.
package wcs_pkg;

	// command codes carried in tuser
	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_LOAD  = 2'd1;
	localparam logic [1:0] CMD_DRAW  = 2'd2;

	// register map: index is paddr[2]
	localparam logic REG_GRID_SPACING = 1'b0;
	localparam logic [15:0] SPACING_RESET = 16'd100;

	localparam int COORD_W = 24;
	localparam logic [COORD_W-1:0] COORD_MAX = 24'hFF_FFFF;
	localparam int TOTAL_W = 28;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = 28'hFFF_FFFF;
	localparam int RAND_W = 16;

	// shared multiplier: rand (16) x total or span (28)
	localparam int PROD_W = RAND_W + TOTAL_W;

	typedef struct packed {
		logic               en;
		logic [RAND_W-1:0]  a;
		logic [TOTAL_W-1:0] b;
	} mul_req_t;

endpackage

// ===== rtl/wcs_mul.sv =====
// Shared registered multiplier used by the draw sequencer.
module wcs_mul (
	input  logic              clk,
	input  wcs_pkg::mul_req_t req,
	output logic [wcs_pkg::PROD_W-1:0] prod
);
	import wcs_pkg::*;

	logic [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= PROD_W'(req.a) * PROD_W'(req.b);
		end
	end

	assign prod = prod_q;

endmodule

// ===== rtl/weighted_cell_sampler.sv =====
// Weighted cell sampler top level: cell table, draw sequencer, APB register.
// Clear and load: a new transaction every cycle while no draw is in progress.
// Draw: target, walk from entry 0 to the pick (one stored entry per cycle through a
// single read port), east and north offsets, result; a failed draw skips the rest.
// Reset clears the fill count, total, sequencer and output valid; spacing goes to 100.
`include "weighted_cell_sampler_macros.svh"

module weighted_cell_sampler #(
	parameter int MAX_CELLS   = 4096,
	parameter int WEIGHT_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	// input stream
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [23:0] cell_east, [47:24] cell_north, [63:48] weight,
	// [79:64] rand_pick, [95:80] rand_east, [111:96] rand_north
	input  logic [111:0] s_axis_tdata,
	// [1:0] cmd
	input  logic [1:0]   s_axis_tuser,
	// result stream
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [23:0] vent_east, [47:24] vent_north, [59:48] cell_index, [63:60] zero
	output logic [63:0]  m_axis_tdata,
	// [0] failed
	output logic [0:0]   m_axis_tuser,
	// configuration
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import wcs_pkg::*;

	// table geometry
	localparam int AW    = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam int CW    = $clog2(MAX_CELLS + 1);
	localparam int SW    = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;
	localparam int ENT_W = 2 * COORD_W + SW;

	// sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_TGT   = 3'd1;
	localparam logic [2:0] S_WALK  = 3'd2;
	localparam logic [2:0] S_EAST  = 3'd3;
	localparam logic [2:0] S_NORTH = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	// saturating add into the 28-bit total
	function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
			input logic [SW-1:0] b);
		logic [TOTAL_W:0] t;
		t = {1'b0, a} + (TOTAL_W + 1)'(b);
		return t[TOTAL_W] ? TOTAL_MAX : t[TOTAL_W-1:0];
	endfunction

	// centre - ceil(s/2) + offset, clamped to the coordinate range
	function automatic logic [COORD_W-1:0] place(input logic [COORD_W-1:0] c,
			input logic [16:0] half, input logic [16:0] off);
		logic signed [COORD_W+1:0] p;
		p = $signed({2'b00, c}) - $signed((COORD_W + 2)'(half))
			+ $signed((COORD_W + 2)'(off));
		if (p < 0) begin
			return '0;
		end else if (p > $signed({2'b00, COORD_MAX})) begin
			return COORD_MAX;
		end else begin
			return p[COORD_W-1:0];
		end
	endfunction

	// input fields
	logic [1:0]         in_cmd;
	logic [COORD_W-1:0] in_east, in_north;
	logic [15:0]        in_weight;
	logic [RAND_W-1:0]  in_rpick, in_reast, in_rnorth;

	assign in_cmd    = s_axis_tuser;
	assign in_east   = s_axis_tdata[23:0];
	assign in_north  = s_axis_tdata[47:24];
	assign in_weight = s_axis_tdata[63:48];
	assign in_rpick  = s_axis_tdata[79:64];
	assign in_reast  = s_axis_tdata[95:80];
	assign in_rnorth = s_axis_tdata[111:96];

	// control state
	logic [2:0]         state_q;
	logic [CW-1:0]      count_q;
	logic [TOTAL_W-1:0] total_q;
	logic [15:0]        spacing_q;
	logic               fail_q;
	logic               m_tvalid_q;

	// datapath
	logic [ENT_W-1:0]   cell_mem_q [MAX_CELLS];
	logic [ENT_W-1:0]   rdata_q;
	logic [AW-1:0]      idx_q, pick_q;
	logic [TOTAL_W-1:0] sum_q;
	logic [RAND_W-1:0]  rpick_q, reast_q, rnorth_q;
	logic [COORD_W-1:0] east_c_q, north_c_q, vent_east_q;
	logic [63:0]        m_tdata_q;
	logic [0:0]         m_tuser_q;

	logic               in_acc, cfg_wr, mem_we, out_free, out_load, walk_hit;
	logic [AW-1:0]      raddr;
	logic [TOTAL_W-1:0] target, sum_new;
	logic [16:0]        span, half;
	logic [COORD_W-1:0] vent_north;
	logic [PROD_W-1:0]  prod;
	mul_req_t           mul_req;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_tvalid_q || m_axis_tready;
	assign out_load = (state_q == S_DONE) && out_free;

	// APB: single register, always ready
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_GRID_SPACING);
	assign prdata = (paddr[2] == REG_GRID_SPACING) ? {16'b0, spacing_q} : '0;

	// per-axis span s+1 and lower bound offset ceil(s/2)
	assign span = {1'b0, spacing_q} + 17'd1;
	assign half = span >> 1;

	// target = rand_pick * total >> 16, held in the multiplier during the walk
	assign target  = prod[PROD_W-1:RAND_W];
	assign sum_new = sat_add(sum_q, rdata_q[SW-1:0]);
	// last loaded cell is taken if no prefix sum reaches the target
	assign walk_hit = (sum_new >= target) || (CW'(idx_q) == count_q - CW'(1));

	// table write on load while room remains
	assign mem_we = in_acc && (in_cmd == CMD_LOAD) && (count_q < CW'(MAX_CELLS));
	// read entry 0 while the target is computed, then stream ahead by one
	assign raddr  = (state_q == S_TGT) ? '0 : idx_q + AW'(1);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			cell_mem_q[count_q[AW-1:0]] <= {in_east, in_north, in_weight[SW-1:0]};
		end
		rdata_q <= cell_mem_q[raddr];
	end

	// shared multiplier operand select
	always_comb begin
		mul_req.en = 1'b0;
		mul_req.a  = rpick_q;
		mul_req.b  = total_q;
		case (state_q)
			S_TGT: begin
				mul_req.en = 1'b1;
			end
			S_EAST: begin
				mul_req.en = 1'b1;
				mul_req.a  = reast_q;
				mul_req.b  = TOTAL_W'(span);
			end
			S_NORTH: begin
				mul_req.en = 1'b1;
				mul_req.a  = rnorth_q;
				mul_req.b  = TOTAL_W'(span);
			end
			default: begin
				mul_req.en = 1'b0;
			end
		endcase
	end

	wcs_mul u_mul (
		.clk  (clk),
		.req  (mul_req),
		.prod (prod)
	);

	// offset = rand * (s+1) >> 16
	assign vent_north = place(north_c_q, half, prod[RAND_W+16:RAND_W]);

	// sequencer, table bookkeeping, register, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			total_q    <= '0;
			spacing_q  <= SPACING_RESET;
			fail_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				spacing_q <= pwdata[15:0];
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						case (in_cmd)
							CMD_CLEAR: begin
								count_q <= '0;
								total_q <= '0;
							end
							CMD_LOAD: begin
								if (mem_we) begin
									count_q <= count_q + CW'(1);
									total_q <= sat_add(total_q, in_weight[SW-1:0]);
								end
							end
							CMD_DRAW: begin
								if (count_q == '0 || total_q == '0) begin
									fail_q  <= 1'b1;
									state_q <= S_DONE;
								end else begin
									fail_q  <= 1'b0;
									state_q <= S_TGT;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_TGT: begin
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (walk_hit) begin
						state_q <= S_EAST;
					end
				end
				S_EAST: begin
					state_q <= S_NORTH;
				end
				S_NORTH: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// draw datapath registers
	always_ff @(posedge clk) begin
		if (in_acc && in_cmd == CMD_DRAW) begin
			rpick_q  <= in_rpick;
			reast_q  <= in_reast;
			rnorth_q <= in_rnorth;
		end
		if (state_q == S_TGT) begin
			idx_q <= '0;
			sum_q <= '0;
		end else if (state_q == S_WALK) begin
			idx_q <= idx_q + AW'(1);
			sum_q <= sum_new;
			if (walk_hit) begin
				pick_q    <= idx_q;
				east_c_q  <= rdata_q[ENT_W-1 -: COORD_W];
				north_c_q <= rdata_q[SW +: COORD_W];
			end
		end
		if (state_q == S_NORTH) begin
			vent_east_q <= place(east_c_q, half, prod[RAND_W+16:RAND_W]);
		end
		// flag is captured with the payload so it holds while the result waits
		if (out_load) begin
			m_tuser_q <= fail_q;
			if (fail_q) begin
				m_tdata_q <= '0;
			end else begin
				m_tdata_q <= {4'b0, 12'(32'(pick_q)), vent_north, vent_east_q};
			end
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tuser  = m_tuser_q;

	// the walk never reads past the filled part of the table
	`WCS_ASSERT_IMP(a_walk_in_fill, state_q == S_WALK, CW'(idx_q) < count_q, "walk past fill")
	// an empty table carries no weight
	`WCS_ASSERT_IMP(a_empty_total, count_q == '0, total_q == '0, "weight on empty table")
	// a failed draw reports a zero point and index
	`WCS_ASSERT_IMP(a_fail_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0,
		"failed draw with payload")
	// a finished draw reaches the output the next cycle
	`WCS_ASSERT_NXT(a_done_out, out_load, m_axis_tvalid && s_axis_tready, "result not posted")

endmodule
